FILE: hdl/swsr_pkg.sv
// Shared types and constants of the single-wire sensor reader.
package swsr_pkg;

  localparam int unsigned FRAME_BYTES = 5;
  localparam int unsigned FRAME_BITS  = FRAME_BYTES * 8;

  localparam logic [15:0] START_LOW_RESET = 16'd500;
  localparam logic [7:0]  RELEASE_RESET   = 8'd30;
  localparam logic [7:0]  THRESHOLD_RESET = 8'd50;

  localparam logic [14:0] MAG_MASK = 15'h7FFF;

  // configuration register indexes
  localparam logic [1:0] CFG_START_LOW = 2'd0;
  localparam logic [1:0] CFG_RELEASE   = 2'd1;
  localparam logic [1:0] CFG_THRESHOLD = 2'd2;

  typedef enum logic [7:0] {
    PH_IDLE     = 8'b0000_0001,
    PH_REQ_LOW  = 8'b0000_0010,
    PH_RELEASE  = 8'b0000_0100,
    PH_ACK_LOW  = 8'b0000_1000,
    PH_ACK_HIGH = 8'b0001_0000,
    PH_ACK_END  = 8'b0010_0000,
    PH_BIT_WAIT = 8'b0100_0000,
    PH_BIT_TIME = 8'b1000_0000
  } phase_e;

  typedef struct packed {
    logic                  we;
    logic [1:0]            index;
    logic [15:0]           data;
  } cfg_t;

  typedef struct packed {
    logic                  drive_low;
    logic                  busy_res;
    logic                  frame_done;
    logic                  checksum_error;
    logic signed [15:0]    humidity_tenths;
    logic signed [15:0]    temperature_tenths;
    logic [FRAME_BITS-1:0] raw_frame;
  } res_t;

  // sign-magnitude 16-bit field to two's complement; negative zero gives 0
  function automatic logic signed [15:0] sign_mag(input logic [15:0] v);
    logic signed [15:0] mag;
    mag = signed'({1'b0, v[14:0] & MAG_MASK});
    return v[15] ? -mag : mag;
  endfunction

endpackage

FILE: hdl/single_wire_sensor_reader.sv
// Top level of the single-wire humidity and temperature sensor reader.
// Result: one per item, into the result register, or the skid register while stalled.
// Throughput: one item per cycle when not stalled; the sequencer updates at every transfer.
// Output: result register plus skid register, so input takes one more item while a
//   result is stalled; input stall is the registered skid-full flag.
// Reset (async, active low): idle, counters and frames zero, registers 500/30/50.
module single_wire_sensor_reader (
  input  logic               clk_i,
  input  logic               rst_ni,
  // configuration write port
  input  logic               cfg_we_i,
  input  logic [1:0]         cfg_index_i,
  input  logic [15:0]        cfg_data_i,
  // tick / start input channel
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic               action_i,
  input  logic               line_level_i,
  // result channel
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic               drive_low_o,
  output logic               busy_res_o,
  output logic               frame_done_o,
  output logic               checksum_error_o,
  output logic signed [15:0] humidity_tenths_o,
  output logic signed [15:0] temperature_tenths_o,
  output logic [39:0]        raw_frame_o
);

  swsr_pkg::cfg_t cfg;
  swsr_pkg::res_t res_next;
  swsr_pkg::res_t res_out;
  logic           full;
  logic           accept;

  assign cfg.we    = cfg_we_i;
  assign cfg.index = cfg_index_i;
  assign cfg.data  = cfg_data_i;

  // a transfer is taken whenever the skid slot is free
  assign in_stall_o = full;
  assign accept     = in_valid_i && !full;

  // sequencer state and result computed in the transfer cycle
  swsr_core u_core (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg),
    .accept_i     (accept),
    .action_i     (action_i),
    .line_level_i (line_level_i),
    .res_o        (res_next)
  );

  swsr_skid u_skid (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (accept),
    .res_i       (res_next),
    .full_o      (full),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .res_o       (res_out)
  );

  assign drive_low_o          = res_out.drive_low;
  assign busy_res_o           = res_out.busy_res;
  assign frame_done_o         = res_out.frame_done;
  assign checksum_error_o     = res_out.checksum_error;
  assign humidity_tenths_o    = res_out.humidity_tenths;
  assign temperature_tenths_o = res_out.temperature_tenths;
  assign raw_frame_o          = res_out.raw_frame;

  a_drive_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && drive_low_o) |-> busy_res_o)
    else $error("line driven low while not busy");
  a_done_not_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && frame_done_o) |-> !busy_res_o)
    else $error("frame done while still busy");
  a_accept_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> out_valid_o)
    else $error("transfer produced no result");

endmodule

FILE: hdl/swsr_core.sv
// Line sequencer, bit timer and frame checker of the sensor reader.
module swsr_core (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  swsr_pkg::cfg_t      cfg_i,
  input  logic                accept_i,
  input  logic                action_i,
  input  logic                line_level_i,
  output swsr_pkg::res_t      res_o
);

  logic [15:0] start_low_q;
  logic [7:0]  release_q;
  logic [7:0]  threshold_q;

  swsr_pkg::phase_e phase_q, phase_d;
  logic [15:0] tick_q, tick_d;
  logic [7:0]  pulse_q, pulse_d;
  logic [5:0]  bits_q, bits_d;
  logic [swsr_pkg::FRAME_BITS-1:0] shift_q, shift_d;
  logic [swsr_pkg::FRAME_BITS-1:0] frame_q, frame_d;
  logic        error_q, error_d;
  logic        done;

  logic [15:0] tick_inc;
  logic [7:0]  pulse_inc;
  logic [5:0]  bits_inc;
  logic        bit_val;
  logic [swsr_pkg::FRAME_BITS-1:0] shift_new;
  logic [7:0]  sum;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_low_q <= swsr_pkg::START_LOW_RESET;
      release_q   <= swsr_pkg::RELEASE_RESET;
      threshold_q <= swsr_pkg::THRESHOLD_RESET;
    end else if (cfg_i.we) begin
      unique case (cfg_i.index)
        swsr_pkg::CFG_START_LOW: start_low_q <= cfg_i.data;
        swsr_pkg::CFG_RELEASE:   release_q   <= cfg_i.data[7:0];
        swsr_pkg::CFG_THRESHOLD: threshold_q <= cfg_i.data[7:0];
        default: ;
      endcase
    end
  end

  assign tick_inc  = tick_q + 16'd1;
  assign pulse_inc = (pulse_q == 8'hFF) ? pulse_q : pulse_q + 8'd1;
  assign bits_inc  = bits_q + 6'd1;
  assign bit_val   = pulse_inc > threshold_q;
  assign shift_new = {shift_q[swsr_pkg::FRAME_BITS-2:0], bit_val};
  assign sum       = shift_new[39:32] + shift_new[31:24] + shift_new[23:16] + shift_new[15:8];

  always_comb begin
    phase_d = phase_q;
    tick_d  = tick_q;
    pulse_d = pulse_q;
    bits_d  = bits_q;
    shift_d = shift_q;
    frame_d = frame_q;
    error_d = error_q;
    done    = 1'b0;
    if (accept_i) begin
      if (action_i) begin
        // start aborts any reading in flight; the latched frame stays
        phase_d = swsr_pkg::PH_REQ_LOW;
        tick_d  = '0;
        pulse_d = '0;
        bits_d  = '0;
        shift_d = '0;
      end else begin
        unique case (phase_q)
          swsr_pkg::PH_IDLE: ;
          swsr_pkg::PH_REQ_LOW: begin
            tick_d = tick_inc;
            if (tick_inc >= start_low_q) begin
              phase_d = swsr_pkg::PH_RELEASE;
              tick_d  = '0;
            end
          end
          swsr_pkg::PH_RELEASE: begin
            tick_d = tick_inc;
            if (tick_inc >= {8'd0, release_q}) begin
              phase_d = swsr_pkg::PH_ACK_LOW;
              tick_d  = '0;
            end
          end
          swsr_pkg::PH_ACK_LOW:  if (!line_level_i) phase_d = swsr_pkg::PH_ACK_HIGH;
          swsr_pkg::PH_ACK_HIGH: if (line_level_i)  phase_d = swsr_pkg::PH_ACK_END;
          swsr_pkg::PH_ACK_END:  if (!line_level_i) phase_d = swsr_pkg::PH_BIT_WAIT;
          swsr_pkg::PH_BIT_WAIT: begin
            if (line_level_i) begin
              pulse_d = '0;
              phase_d = swsr_pkg::PH_BIT_TIME;
            end
          end
          swsr_pkg::PH_BIT_TIME: begin
            pulse_d = pulse_inc;
            if (!line_level_i) begin
              shift_d = shift_new;
              bits_d  = bits_inc;
              if (bits_inc >= 6'(swsr_pkg::FRAME_BITS)) begin
                error_d = sum != shift_new[7:0];
                frame_d = shift_new;
                done    = 1'b1;
                phase_d = swsr_pkg::PH_IDLE;
              end else begin
                phase_d = swsr_pkg::PH_BIT_WAIT;
              end
            end
          end
          default: phase_d = swsr_pkg::PH_IDLE;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= swsr_pkg::PH_IDLE;
      tick_q  <= '0;
      pulse_q <= '0;
      bits_q  <= '0;
      shift_q <= '0;
      frame_q <= '0;
      error_q <= 1'b0;
    end else begin
      phase_q <= phase_d;
      tick_q  <= tick_d;
      pulse_q <= pulse_d;
      bits_q  <= bits_d;
      shift_q <= shift_d;
      frame_q <= frame_d;
      error_q <= error_d;
    end
  end

  always_comb begin
    res_o.drive_low          = phase_d == swsr_pkg::PH_REQ_LOW;
    res_o.busy_res           = phase_d != swsr_pkg::PH_IDLE;
    res_o.frame_done         = done;
    res_o.checksum_error     = error_d;
    res_o.humidity_tenths    = swsr_pkg::sign_mag(frame_d[39:24]);
    res_o.temperature_tenths = swsr_pkg::sign_mag(frame_d[23:8]);
    res_o.raw_frame          = frame_d;
  end

  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done |=> phase_q == swsr_pkg::PH_IDLE)
    else $error("frame done without return to idle");
  a_bits_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    bits_q <= 6'(swsr_pkg::FRAME_BITS))
    else $error("bit count past frame length");
  a_frame_latch: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !done |=> $stable(frame_q))
    else $error("latched frame changed outside frame end");

endmodule

FILE: hdl/swsr_skid.sv
// Two-entry result buffer: result register plus skid register.
module swsr_skid (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           load_i,
  input  swsr_pkg::res_t res_i,
  output logic           full_o,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output swsr_pkg::res_t res_o
);

  logic           main_valid_q;
  logic           skid_valid_q;
  swsr_pkg::res_t main_q;
  swsr_pkg::res_t skid_q;
  logic           take;

  assign take        = main_valid_q && !out_stall_i;
  assign full_o      = skid_valid_q;
  assign out_valid_o = main_valid_q;
  assign res_o       = main_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      main_valid_q <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (skid_valid_q) begin
      if (take) begin
        main_valid_q <= 1'b1;
        skid_valid_q <= 1'b0;
      end
    end else if (load_i) begin
      if (main_valid_q && !take) skid_valid_q <= 1'b1;
      else                       main_valid_q <= 1'b1;
    end else if (take) begin
      main_valid_q <= 1'b0;
    end
  end

  // payload, no reset
  always_ff @(posedge clk_i) begin
    if (skid_valid_q) begin
      if (take) main_q <= skid_q;
    end else if (load_i) begin
      if (main_valid_q && !take) skid_q <= res_i;
      else                       main_q <= res_i;
    end
  end

  a_skid_main: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> main_valid_q)
    else $error("skid entry without result entry");
  a_skid_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (skid_valid_q && !out_stall_i) |=> (!skid_valid_q && main_valid_q))
    else $error("skid entry not moved on transfer");
  a_no_load_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (skid_valid_q && out_stall_i) |=> skid_valid_q)
    else $error("skid entry lost while stalled");

endmodule

FILE: tb/sensor_checker.sv
// Checker for the single-wire sensor reader: predicts each result and compares it.
module sensor_checker
  import swsr_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [1:0]         cfg_index_i,
  input  logic [15:0]        cfg_data_i,
  input  logic               in_valid_i,
  input  logic               in_stall_i,
  input  logic               action_i,
  input  logic               line_level_i,
  input  logic               out_valid_i,
  input  logic               out_stall_i,
  input  logic               drive_low_i,
  input  logic               busy_res_i,
  input  logic               frame_done_i,
  input  logic               checksum_error_i,
  input  logic signed [15:0] humidity_tenths_i,
  input  logic signed [15:0] temperature_tenths_i,
  input  logic [39:0]        raw_frame_i,
  output int                 fail_count_o,
  output int                 pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  // register copies
  logic [15:0] low_ticks;
  logic [7:0]  release_ticks;
  logic [7:0]  threshold;

  // line sequencer copy
  phase_e      phase_q;
  logic [15:0] ticks_q;
  logic [7:0]  width_q;
  logic [5:0]  bits_q;
  logic [39:0] shift_q;
  logic [39:0] frame_q;
  logic        err_q;

  res_t reading_q[$];
  int   mismatches;
  int   pending_n;

  assign fail_count_o = mismatches;
  assign pending_o    = pending_n;

  // sign-magnitude field to signed tenths; a negative zero comes out as 0
  function automatic logic signed [15:0] tenths_of(input logic [15:0] field);
    logic signed [15:0] magnitude;
    magnitude = signed'({1'b0, field[14:0]});
    if (field[15]) begin
      return 16'sd0 - magnitude;
    end
    return magnitude;
  endfunction

  function automatic res_t sensor_step(input logic start, input logic high);
    res_t       r;
    logic       done;
    logic [7:0] sum;
    done = 1'b0;
    if (start) begin
      phase_q = PH_REQ_LOW;
      ticks_q = '0;
      width_q = '0;
      bits_q  = '0;
      shift_q = '0;
    end else begin
      case (phase_q)
        PH_REQ_LOW: begin
          ticks_q = ticks_q + 16'd1;
          if (ticks_q >= low_ticks) begin
            phase_q = PH_RELEASE;
            ticks_q = '0;
          end
        end
        PH_RELEASE: begin
          ticks_q = ticks_q + 16'd1;
          if (ticks_q >= {8'd0, release_ticks}) begin
            phase_q = PH_ACK_LOW;
            ticks_q = '0;
          end
        end
        PH_ACK_LOW: if (!high) phase_q = PH_ACK_HIGH;
        PH_ACK_HIGH: if (high) phase_q = PH_ACK_END;
        PH_ACK_END: if (!high) phase_q = PH_BIT_WAIT;
        PH_BIT_WAIT: begin
          if (high) begin
            width_q = '0;
            phase_q = PH_BIT_TIME;
          end
        end
        PH_BIT_TIME: begin
          if (width_q != 8'hFF) width_q = width_q + 8'd1;
          if (!high) begin
            shift_q = {shift_q[38:0], width_q > threshold};
            bits_q  = bits_q + 6'd1;
            if (bits_q >= FRAME_BITS) begin
              sum     = shift_q[39:32] + shift_q[31:24] + shift_q[23:16] + shift_q[15:8];
              err_q   = (sum != shift_q[7:0]);
              frame_q = shift_q;
              done    = 1'b1;
              phase_q = PH_IDLE;
            end else begin
              phase_q = PH_BIT_WAIT;
            end
          end
        end
        default: ;
      endcase
    end
    r.drive_low          = (phase_q == PH_REQ_LOW);
    r.busy_res           = (phase_q != PH_IDLE);
    r.frame_done         = done;
    r.checksum_error     = err_q;
    r.humidity_tenths    = tenths_of(frame_q[39:24]);
    r.temperature_tenths = tenths_of(frame_q[23:8]);
    r.raw_frame          = frame_q;
    return r;
  endfunction

  task automatic check_field(input string name, input logic [39:0] want,
                             input logic [39:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %h, got %h", $time, name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    res_t want;
    if (!rst_ni) begin
      low_ticks     = START_LOW_RESET;
      release_ticks = RELEASE_RESET;
      threshold     = THRESHOLD_RESET;
      phase_q       = PH_IDLE;
      ticks_q       = '0;
      width_q       = '0;
      bits_q        = '0;
      shift_q       = '0;
      frame_q       = '0;
      err_q         = 1'b0;
      reading_q.delete();
      mismatches    = 0;
      pending_n     = 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (reading_q.size() == 0) begin
          $display("%0t: result transfer with nothing expected, got frame %h",
                   $time, raw_frame_i);
          mismatches++;
        end else begin
          want = reading_q.pop_front();
          check_field("drive_low", want.drive_low, drive_low_i);
          check_field("busy_res", want.busy_res, busy_res_i);
          check_field("frame_done", want.frame_done, frame_done_i);
          check_field("checksum_error", want.checksum_error, checksum_error_i);
          check_field("humidity_tenths", want.humidity_tenths, humidity_tenths_i);
          check_field("temperature_tenths", want.temperature_tenths, temperature_tenths_i);
          check_field("raw_frame", want.raw_frame, raw_frame_i);
        end
      end
      if (cfg_we_i) begin
        case (cfg_index_i)
          CFG_START_LOW: low_ticks     = cfg_data_i;
          CFG_RELEASE:   release_ticks = cfg_data_i[7:0];
          CFG_THRESHOLD: threshold     = cfg_data_i[7:0];
          default: ;
        endcase
      end
      if (in_valid_i && !in_stall_i) begin
        reading_q.push_back(sensor_step(action_i, line_level_i));
      end
      pending_n = reading_q.size();
    end
  end

endmodule

FILE: tb/tb_top.sv
// Testbench top: clock, reset, stimulus and verdict for the single-wire sensor reader.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import swsr_pkg::*;

  localparam int HALF_PERIOD    = 10;
  localparam int RESET_CYCLES   = 11;
  localparam int WATCHDOG_LIMIT = 2000;  // cycles without any transfer or register write
  localparam int HOLD_CYCLES    = 60;    // long receiver hold-off
  localparam int DRAIN_CYCLES   = 4;     // settle time after the last expected result is in
  localparam int PHASE_ITEMS    = 100;   // random transfers per idling phase
  localparam int LONG_PULSE     = 260;   // high ticks past the 8-bit pulse counter

  // index past the last register; writes to it must change nothing
  localparam logic [1:0] CFG_SPARE = 2'd3;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               cfg_we_i = 1'b0;
  logic [1:0]         cfg_index_i = '0;
  logic [15:0]        cfg_data_i = '0;
  logic               in_valid_i = 1'b0;
  logic               in_stall_o;
  logic               action_i = 1'b0;
  logic               line_level_i = 1'b0;
  logic               out_valid_o;
  logic               out_stall_i = 1'b0;
  logic               drive_low_o;
  logic               busy_res_o;
  logic               frame_done_o;
  logic               checksum_error_o;
  logic signed [15:0] humidity_tenths_o;
  logic signed [15:0] temperature_tenths_o;
  logic [39:0]        raw_frame_o;

  int fail_count;
  int pending;

  // idling knobs, percent of cycles
  int   send_idle_pct = 0;
  int   stall_pct = 0;
  logic hold_req = 1'b0;

  // testbench view of the registers, used to shape well-formed readings
  int low_now = START_LOW_RESET;
  int rel_now = RELEASE_RESET;
  int thr_now = THRESHOLD_RESET;
  int items_sent = 0;

  always #(HALF_PERIOD) clk_i = ~clk_i;

  single_wire_sensor_reader i_dut (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .cfg_we_i             (cfg_we_i),
    .cfg_index_i          (cfg_index_i),
    .cfg_data_i           (cfg_data_i),
    .in_valid_i           (in_valid_i),
    .in_stall_o           (in_stall_o),
    .action_i             (action_i),
    .line_level_i         (line_level_i),
    .out_valid_o          (out_valid_o),
    .out_stall_i          (out_stall_i),
    .drive_low_o          (drive_low_o),
    .busy_res_o           (busy_res_o),
    .frame_done_o         (frame_done_o),
    .checksum_error_o     (checksum_error_o),
    .humidity_tenths_o    (humidity_tenths_o),
    .temperature_tenths_o (temperature_tenths_o),
    .raw_frame_o          (raw_frame_o)
  );

  sensor_checker i_checker (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .cfg_we_i             (cfg_we_i),
    .cfg_index_i          (cfg_index_i),
    .cfg_data_i           (cfg_data_i),
    .in_valid_i           (in_valid_i),
    .in_stall_i           (in_stall_o),
    .action_i             (action_i),
    .line_level_i         (line_level_i),
    .out_valid_i          (out_valid_o),
    .out_stall_i          (out_stall_i),
    .drive_low_i          (drive_low_o),
    .busy_res_i           (busy_res_o),
    .frame_done_i         (frame_done_o),
    .checksum_error_i     (checksum_error_o),
    .humidity_tenths_i    (humidity_tenths_o),
    .temperature_tenths_i (temperature_tenths_o),
    .raw_frame_i          (raw_frame_o),
    .fail_count_o         (fail_count),
    .pending_o            (pending)
  );

  // Watchdog: any transfer on either channel or a register write counts as progress.
  logic activity;
  int   quiet_cycles = 0;
  assign activity = (in_valid_i & ~in_stall_o) | (out_valid_o & ~out_stall_i) | cfg_we_i;

  always @(posedge clk_i) begin
    if (!rst_ni || activity) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // Result side. A hold-off request stalls the output for a fixed stretch, counted
  // here, so the skid fills and the block pushes back on its input.
  always begin
    @(negedge clk_i);
    if (hold_req) begin
      hold_req    = 1'b0;
      out_stall_i = 1'b1;
      repeat (HOLD_CYCLES) @(negedge clk_i);
    end
    out_stall_i = ($urandom_range(99) < stall_pct);
  end

  // One transfer on the input channel. Called at a falling edge, returns at one.
  // Idle cycles carry junk payload with valid low.
  task automatic send_item(input logic act, input logic lvl);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i   = 1'b0;
      action_i     = 1'($urandom);
      line_level_i = 1'($urandom);
      @(negedge clk_i);
    end
    in_valid_i   = 1'b1;
    action_i     = act;
    line_level_i = lvl;
    items_sent++;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic ticks(input int n, input logic lvl);
    repeat (n) send_item(1'b0, lvl);
  endtask

  // line level does not matter during request and release; randomize it
  task automatic loose_ticks(input int n);
    repeat (n) send_item(1'b0, 1'($urandom));
  endtask

  // Stop offering, wait for every expected result, then let the block settle.
  task automatic drain();
    in_valid_i = 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_cfg(input logic [1:0] idx, input logic [15:0] value);
    cfg_we_i    = 1'b1;
    cfg_index_i = idx;
    cfg_data_i  = value;
    @(negedge clk_i);
    cfg_we_i    = 1'b0;
    case (idx)
      CFG_START_LOW: low_now = value;
      CFG_RELEASE:   rel_now = value[7:0];
      CFG_THRESHOLD: thr_now = value[7:0];
      default: ;
    endcase
  endtask

  // Upper byte of the 8-bit registers gets junk; the block must drop it.
  task automatic set_regs(input int low, input int rel, input int thr);
    drain();
    write_cfg(CFG_START_LOW, 16'(low));
    write_cfg(CFG_RELEASE, {8'($urandom), 8'(rel)});
    write_cfg(CFG_THRESHOLD, {8'($urandom), 8'(thr)});
  endtask

  task automatic set_idling(input int sender, input int receiver);
    send_idle_pct = sender;
    stall_pct     = receiver;
  endtask

  // Humidity or temperature field, biased to sign-magnitude corners (negative zero,
  // largest magnitudes of both signs, zero).
  function automatic logic [15:0] pick_field();
    case ($urandom_range(5))
      0: return 16'h8000;
      1: return 16'hFFFF;
      2: return 16'h7FFF;
      3: return 16'h0000;
      default: return 16'($urandom);
    endcase
  endfunction

  // Mostly a valid checksum, sometimes a corrupt one.
  function automatic logic [39:0] make_frame();
    logic [15:0] hum;
    logic [15:0] temp;
    logic [7:0]  check;
    hum   = pick_field();
    temp  = pick_field();
    check = hum[15:8] + hum[7:0] + temp[15:8] + temp[7:0];
    if ($urandom_range(4) == 0) check = 8'($urandom);
    return {hum, temp, check};
  endfunction

  // Full sensor conversation: start, request low, release, ack low/high/low, then one
  // high pulse per bit. stop_after < FRAME_BITS leaves the frame unfinished so that
  // the next start aborts it. long_bit gets a pulse that saturates the width counter.
  task automatic read_sensor(input logic [39:0] frame, input int stop_after,
                             input int long_bit);
    int i;
    int width;
    send_item(1'b1, 1'($urandom));
    loose_ticks(((low_now == 0) ? 1 : low_now) + ((rel_now == 0) ? 1 : rel_now));
    ticks($urandom_range(2, 1), 1'b0);
    ticks($urandom_range(2, 1), 1'b1);
    ticks($urandom_range(2, 1), 1'b0);
    for (i = 0; i < FRAME_BITS && i != stop_after; i++) begin
      if (i == long_bit) width = LONG_PULSE;
      else if (frame[FRAME_BITS-1-i]) width = (thr_now >= 255) ? 1 : thr_now + $urandom_range(2, 1);
      else width = (thr_now == 0) ? 1 : $urandom_range(thr_now, 1);
      ticks(width, 1'b1);
      // the first low decodes the bit, extra lows wait for the next pulse
      ticks($urandom_range(2, 1), 1'b0);
    end
  endtask

  // Junk between readings: idle ticks and the odd stray start.
  task automatic noise(input int n);
    repeat (n) send_item($urandom_range(9) == 0, 1'($urandom));
  endtask

  // Mostly well-formed readings with random content, some aborted, some junk.
  task automatic run_phase(input int budget);
    int first;
    int pick;
    first = items_sent;
    while (items_sent - first < budget) begin
      pick = $urandom_range(9);
      if (pick < 7) read_sensor(make_frame(), -1, (pick == 0) ? $urandom_range(39) : -1);
      else if (pick < 9) read_sensor(make_frame(), $urandom_range(39), -1);
      else noise($urandom_range(12, 1));
      noise($urandom_range(6));
    end
  endtask

  initial begin
    repeat (RESET_CYCLES) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Directed: ticks while idle change nothing, a start with either line level,
    // and a start while busy restarts the request.
    ticks(1, 1'b0);
    ticks(1, 1'b1);
    send_item(1'b1, 1'b1);
    loose_ticks(3);
    send_item(1'b1, 1'b0);
    ticks(2, 1'b1);
    send_item(1'b1, 1'b1);
    ticks(2, 1'b0);

    // Reset register values: the request low holds under the default length.
    send_item(1'b1, 1'($urandom));
    loose_ticks(40);
    noise(4);

    // Shortest delays; sender mostly idle.
    set_idling(82, 0);
    set_regs(1, 1, 1);
    run_phase(PHASE_ITEMS);

    // Zero delays behave as one tick; receiver mostly stalled.
    set_idling(0, 82);
    set_regs(0, 0, 1);
    run_phase(PHASE_ITEMS);

    // Both sides idle a little. Long receiver hold-off at the start while the sender
    // keeps offering. Threshold at its top: short pulses sent as ones read as zero.
    set_idling(14, 14);
    set_regs(3, 6, 255);
    hold_req = 1'b1;
    read_sensor(40'hFF_FFFF_FFFF, -1, -1);
    // Threshold zero: every pulse is a one; the second pulse saturates the width
    // counter, and the reading is left after three bits.
    set_regs(2, 1, 0);
    read_sensor(make_frame(), 3, 1);
    // Longest request low, left running across writes past the last register,
    // which must leave the others alone.
    set_regs(65535, 9, 1);
    write_cfg(CFG_SPARE, 16'hFFFF);
    send_item(1'b1, 1'b0);
    loose_ticks(20);
    drain();
    write_cfg(CFG_SPARE, 16'h0000);
    loose_ticks(20);

    // No idling at all, with a full pause in the middle until every result is in.
    set_idling(0, 0);
    set_regs(4, 2, 1);
    run_phase(PHASE_ITEMS / 2);
    drain();
    run_phase(PHASE_ITEMS / 2);

    drain();
    repeat (10) @(negedge clk_i);
    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

FILE: single_wire_sensor_reader.f
hdl/swsr_pkg.sv
hdl/swsr_core.sv
hdl/swsr_skid.sv
hdl/single_wire_sensor_reader.sv
tb/sensor_checker.sv
tb/tb_top.sv
